@@ rtl/utfgs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 grapheme segmenter package
// Shared types, code point constants and classification functions.
// ----------------------------------------------------------------------------
package utfgs_pkg;

    localparam int CP_W        = 21;
    localparam int OUT_OFF_W   = 32;
    localparam int LEN_W       = 3;
    localparam int MAX_RESULTS = 5;
    localparam int MAX_UNITS   = 4;
    localparam int CNT_W       = 3;
    localparam int PEND_DEPTH  = 3;

    localparam logic [CP_W-1:0] CP_REPL    = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_ZWJ     = 21'h00200D;
    localparam logic [CP_W-1:0] CP_RI_LO   = 21'h01F1E6;
    localparam logic [CP_W-1:0] CP_RI_HI   = 21'h01F1FF;
    localparam logic [CP_W-1:0] CP_CM_LO   = 21'h000300;
    localparam logic [CP_W-1:0] CP_CM_HI   = 21'h00036F;
    localparam logic [CP_W-1:0] CP_CME_LO  = 21'h001AB0;
    localparam logic [CP_W-1:0] CP_CME_HI  = 21'h001AFF;
    localparam logic [CP_W-1:0] CP_CMS_LO  = 21'h001DC0;
    localparam logic [CP_W-1:0] CP_CMS_HI  = 21'h001DFF;
    localparam logic [CP_W-1:0] CP_CMY_LO  = 21'h0020D0;
    localparam logic [CP_W-1:0] CP_CMY_HI  = 21'h0020FF;
    localparam logic [CP_W-1:0] CP_HALF_LO = 21'h00FE20;
    localparam logic [CP_W-1:0] CP_HALF_HI = 21'h00FE2F;
    localparam logic [CP_W-1:0] CP_VS_LO   = 21'h00FE00;
    localparam logic [CP_W-1:0] CP_VS_HI   = 21'h00FE0F;
    localparam logic [CP_W-1:0] CP_VSS_LO  = 21'h0E0100;
    localparam logic [CP_W-1:0] CP_VSS_HI  = 21'h0E01EF;
    localparam logic [CP_W-1:0] CP_SKIN_LO = 21'h01F3FB;
    localparam logic [CP_W-1:0] CP_SKIN_HI = 21'h01F3FF;

    typedef enum logic [2:0] {
        MODE_START = 3'd0,
        MODE_BASE  = 3'd1,
        MODE_ZWJ   = 3'd2,
        MODE_RI1   = 3'd3,
        MODE_RI2   = 3'd4
    } t_mode;

    typedef struct packed {
        logic [CP_W-1:0]      char_code;
        logic [OUT_OFF_W-1:0] byte_offset;
        logic [LEN_W-1:0]     unit_length;
        logic                 cluster_start;
        logic                 replaced;
        logic                 end_of_text;
    } t_result;

    typedef t_result [MAX_RESULTS-1:0] t_batch;

    typedef struct packed {
        logic       final_byte;
        logic [7:0] text_byte;
    } t_in_item;

    typedef struct packed {
        logic  start;
        t_mode mode;
    } t_mode_step;

    function automatic logic in_range(logic [CP_W-1:0] cp, logic [CP_W-1:0] lo,
                                      logic [CP_W-1:0] hi);
        return (cp >= lo) && (cp <= hi);
    endfunction

    function automatic logic is_extender(logic [CP_W-1:0] cp);
        return in_range(cp, CP_CM_LO, CP_CM_HI) || in_range(cp, CP_CME_LO, CP_CME_HI) ||
               in_range(cp, CP_CMS_LO, CP_CMS_HI) || in_range(cp, CP_CMY_LO, CP_CMY_HI) ||
               in_range(cp, CP_HALF_LO, CP_HALF_HI) || in_range(cp, CP_VS_LO, CP_VS_HI) ||
               in_range(cp, CP_VSS_LO, CP_VSS_HI) || in_range(cp, CP_SKIN_LO, CP_SKIN_HI);
    endfunction

    function automatic logic is_ri(logic [CP_W-1:0] cp);
        return in_range(cp, CP_RI_LO, CP_RI_HI);
    endfunction

    // Sequence length announced by a lead byte, zero for anything else.
    function automatic logic [LEN_W-1:0] lead_len(logic [7:0] b);
        logic [LEN_W-1:0] len;
        len = '0;
        if (b[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic t_mode_step mode_step(t_mode m, logic [CP_W-1:0] cp);
        t_mode_step s;
        s.start = 1'b0;
        s.mode  = m;
        case (m)
            MODE_BASE: begin
                if (is_extender(cp)) begin
                    s.mode = MODE_BASE;
                end else if (cp == CP_ZWJ) begin
                    s.mode = MODE_ZWJ;
                end else begin
                    s.start = 1'b1;
                end
            end
            MODE_ZWJ: begin
                s.mode = MODE_BASE;
            end
            MODE_RI1: begin
                if (is_ri(cp)) begin
                    s.mode = MODE_RI2;
                end else begin
                    s.start = 1'b1;
                end
            end
            default: begin
                s.start = 1'b1;
            end
        endcase
        if (s.start) begin
            s.mode = is_ri(cp) ? MODE_RI1 : MODE_BASE;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

@@ rtl/utf8_grapheme_segmenter_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 grapheme segmenter core
// Decodes a UTF-8 byte stream into code points with grapheme cluster marks.
// ----------------------------------------------------------------------------
// The block takes one text byte per transaction, with tlast on the final byte
// of a text, and returns one transaction per decoded unit plus an end item
// after the final byte; tlast on the result side marks the last result caused
// by an input byte. While results are taken, bytes that cause at most one
// result stream at one byte per cycle; a byte with n results (up to five) holds
// the port until all are taken, as the result stage presents one result per
// cycle while the receiver is ready. A byte's first result passes the input
// and result registers. The input ready is registered behind a skid entry, so
// a byte is still taken while a result waits. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module utf8_grapheme_segmenter_core #(
    parameter int OFFSET_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // text_byte
    input  wire         i_s_tlast,   // final_byte
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [55:0] o_m_tdata,   // char_code[20:0], byte_offset[52:21], unit_length[55:53]
    output logic [2:0]  o_m_tuser,   // cluster_start[0], replaced[1], end_of_text[2]
    output logic        o_m_tlast    // run_last
);
    import utfgs_pkg::*;

    logic             head_valid;
    t_in_item         head_item;
    logic             load;
    logic             free;
    t_batch           batch;
    logic [CNT_W-1:0] batch_cnt;

    utfgs_skid u_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_valid    (head_valid),
        .o_item     (head_item),
        .i_take     (load)
    );

    utfgs_decode #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_item  (head_item),
        .i_free  (free),
        .o_load  (load),
        .o_batch (batch),
        .o_cnt   (batch_cnt)
    );

    utfgs_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_batch    (batch),
        .i_cnt      (batch_cnt),
        .o_free     (free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire

@@ rtl/utfgs_skid.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 grapheme segmenter input stage
// Input register with a skid entry so that the ready output is registered.
// ----------------------------------------------------------------------------
module utfgs_skid (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    input  wire  [7:0]           i_s_tdata,   // text_byte
    input  wire                  i_s_tlast,   // final_byte
    output logic                 o_valid,
    output utfgs_pkg::t_in_item  o_item,
    input  wire                  i_take
);
    import utfgs_pkg::*;

    logic     r_main_valid;
    logic     r_skid_valid;
    t_in_item r_main;
    t_in_item r_skid;
    logic     s_accept;
    logic     consume;

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign consume    = r_main_valid && i_take;
    assign o_s_tready = !r_skid_valid;
    assign o_valid    = r_main_valid;
    assign o_item     = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (consume) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= s_accept;
            end
        end else if (s_accept) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (s_accept) begin
                r_main <= '{final_byte: i_s_tlast, text_byte: i_s_tdata};
            end
        end else if (s_accept) begin
            if (r_main_valid) begin
                r_skid <= '{final_byte: i_s_tlast, text_byte: i_s_tdata};
            end else begin
                r_main <= '{final_byte: i_s_tlast, text_byte: i_s_tdata};
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/utfgs_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 grapheme segmenter decode stage
// Holds the open sequence and cluster state and forms the batch of results
// that one input byte causes.
// ----------------------------------------------------------------------------
module utfgs_decode #(
    parameter int OFFSET_BITS = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  utfgs_pkg::t_in_item  i_item,
    input  wire                  i_free,
    output logic                 o_load,
    output utfgs_pkg::t_batch    o_batch,
    output logic [utfgs_pkg::CNT_W-1:0] o_cnt
);
    import utfgs_pkg::*;

    logic [7:0]             r_pend [PEND_DEPTH];
    logic [1:0]             r_pcnt;
    logic [LEN_W-1:0]       r_exp;
    logic [OFFSET_BITS-1:0] r_bcnt;
    logic [OFFSET_BITS-1:0] r_seq;
    t_mode                  r_mode;

    logic [7:0]             n_pend [PEND_DEPTH];
    logic [1:0]             n_pcnt;
    logic [LEN_W-1:0]       n_exp;
    logic [OFFSET_BITS-1:0] n_bcnt;
    logic [OFFSET_BITS-1:0] n_seq;
    t_mode                  n_mode;

    logic [7:0]             b;
    logic                   fin;
    logic                   open;
    logic                   cont;
    logic                   complete;
    logic [LEN_W-1:0]       f_len;
    logic [1:0]             q_cnt;
    logic [OFFSET_BITS-1:0] bcnt_inc;
    logic [CP_W-1:0]        full_cp;
    logic [CP_W-1:0]        u_cp   [MAX_UNITS];
    logic [OFFSET_BITS-1:0] u_off  [MAX_UNITS];
    logic [LEN_W-1:0]       u_len  [MAX_UNITS];
    logic                   u_repl [MAX_UNITS];
    logic                   u_cs   [MAX_UNITS];
    logic [CNT_W-1:0]       nu;
    t_mode                  m;
    t_mode_step             ms;

    assign o_load   = i_valid && i_free;
    assign b        = i_item.text_byte;
    assign fin      = i_item.final_byte;
    assign bcnt_inc = r_bcnt + OFFSET_BITS'(1);
    assign open     = (r_pcnt != 2'd0) && (r_exp >= 3'd2) && (r_exp <= 3'd4);
    assign cont     = (b[7:6] == 2'b10);
    assign complete = open && cont && ({1'b0, r_pcnt} + 3'd1 == r_exp);
    assign f_len    = lead_len(b);

    always_comb begin
        case (r_exp)
            3'd2:    full_cp = {10'd0, r_pend[0][4:0], b[5:0]};
            3'd3:    full_cp = {5'd0, r_pend[0][3:0], r_pend[1][5:0], b[5:0]};
            default: full_cp = {r_pend[0][2:0], r_pend[1][5:0], r_pend[2][5:0], b[5:0]};
        endcase
    end

    always_comb begin
        for (int k = 0; k < MAX_UNITS; k++) begin
            u_cp[k]   = '0;
            u_off[k]  = '0;
            u_len[k]  = '0;
            u_repl[k] = 1'b0;
        end
        nu     = '0;
        n_pend = r_pend;
        q_cnt  = 2'd0;
        n_exp  = '0;
        n_seq  = r_seq;

        if (open && !cont) begin
            for (int i = 0; i < PEND_DEPTH; i++) begin
                if (2'(i) < r_pcnt) begin
                    u_cp[nu[1:0]]   = CP_REPL;
                    u_off[nu[1:0]]  = r_seq + OFFSET_BITS'(i);
                    u_len[nu[1:0]]  = 3'd1;
                    u_repl[nu[1:0]] = 1'b1;
                    nu = nu + 3'd1;
                end
            end
        end

        if (complete) begin
            u_cp[nu[1:0]]  = full_cp;
            u_off[nu[1:0]] = r_seq;
            u_len[nu[1:0]] = r_exp;
            nu = nu + 3'd1;
        end else if (open && cont) begin
            n_pend[r_pcnt] = b;
            q_cnt = r_pcnt + 2'd1;
            n_exp = r_exp;
        end else if (!b[7]) begin
            u_cp[nu[1:0]]  = {13'd0, b};
            u_off[nu[1:0]] = r_bcnt;
            u_len[nu[1:0]] = 3'd1;
            nu = nu + 3'd1;
        end else if (f_len != 3'd0) begin
            n_pend[0] = b;
            q_cnt = 2'd1;
            n_exp = f_len;
            n_seq = r_bcnt;
        end else begin
            u_cp[nu[1:0]]   = CP_REPL;
            u_off[nu[1:0]]  = r_bcnt;
            u_len[nu[1:0]]  = 3'd1;
            u_repl[nu[1:0]] = 1'b1;
            nu = nu + 3'd1;
        end

        n_pcnt = q_cnt;
        n_bcnt = bcnt_inc;
        if (fin) begin
            for (int i = 0; i < PEND_DEPTH; i++) begin
                if (2'(i) < q_cnt) begin
                    u_cp[nu[1:0]]   = CP_REPL;
                    u_off[nu[1:0]]  = n_seq + OFFSET_BITS'(i);
                    u_len[nu[1:0]]  = 3'd1;
                    u_repl[nu[1:0]] = 1'b1;
                    nu = nu + 3'd1;
                end
            end
            n_pcnt = 2'd0;
            n_exp  = '0;
            n_bcnt = '0;
        end
    end

    always_comb begin
        m  = r_mode;
        ms = '{start: 1'b0, mode: MODE_START};
        for (int k = 0; k < MAX_UNITS; k++) begin
            u_cs[k] = 1'b0;
            if (CNT_W'(k) < nu) begin
                ms      = mode_step(m, u_cp[k]);
                u_cs[k] = ms.start;
                m       = ms.mode;
            end
        end
        n_mode = fin ? MODE_START : m;
    end

    always_comb begin
        o_batch = '0;
        for (int k = 0; k < MAX_UNITS; k++) begin
            if (CNT_W'(k) < nu) begin
                o_batch[k].char_code     = u_cp[k];
                o_batch[k].byte_offset   = OUT_OFF_W'(u_off[k]);
                o_batch[k].unit_length   = u_len[k];
                o_batch[k].cluster_start = u_cs[k];
                o_batch[k].replaced      = u_repl[k];
            end
        end
        if (fin) begin
            o_batch[nu].byte_offset   = OUT_OFF_W'(bcnt_inc);
            o_batch[nu].cluster_start = 1'b1;
            o_batch[nu].end_of_text   = 1'b1;
        end
        o_cnt = nu + CNT_W'(fin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt <= 2'd0;
            r_exp  <= '0;
            r_bcnt <= '0;
            r_mode <= MODE_START;
        end else if (o_load) begin
            r_pcnt <= n_pcnt;
            r_exp  <= n_exp;
            r_bcnt <= n_bcnt;
            r_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_pend <= n_pend;
            r_seq  <= n_seq;
        end
    end

`ifndef SYNTHESIS
    a_pend_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pcnt != 2'd0) |-> ({1'b0, r_pcnt} < r_exp))
        else $error("open sequence holds as many bytes as its length");
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_load && fin) |=> (r_pcnt == 2'd0 && r_bcnt == '0 && r_mode == MODE_START))
        else $error("state not cleared after final byte");
    a_batch_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |-> (o_cnt <= CNT_W'(MAX_RESULTS) && (o_cnt != '0 || !fin)))
        else $error("batch size out of range");
`endif

endmodule
`default_nettype wire

@@ rtl/utfgs_emit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 grapheme segmenter result stage
// Registers one batch of results and shifts it out one transaction per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module utfgs_emit (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_load,
    input  utfgs_pkg::t_batch           i_batch,
    input  wire  [utfgs_pkg::CNT_W-1:0] i_cnt,
    output logic                        o_free,
    output logic                        o_m_tvalid,
    input  wire                         i_m_tready,
    output logic [55:0]                 o_m_tdata,  // char_code, byte_offset, unit_length
    output logic [2:0]                  o_m_tuser,  // cluster_start, replaced, end_of_text
    output logic                        o_m_tlast   // run_last
);
    import utfgs_pkg::*;

    t_batch           r_batch;
    t_batch           n_batch;
    logic [CNT_W-1:0] r_cnt;
    logic             m_accept;

    assign m_accept   = o_m_tvalid && i_m_tready;
    assign o_m_tvalid = (r_cnt != '0);
    assign o_free     = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_m_tready);
    assign o_m_tdata  = {r_batch[0].unit_length, r_batch[0].byte_offset,
                         r_batch[0].char_code};
    assign o_m_tuser  = {r_batch[0].end_of_text, r_batch[0].replaced,
                         r_batch[0].cluster_start};
    assign o_m_tlast  = (r_cnt == CNT_W'(1));

    always_comb begin
        n_batch = r_batch;
        if (i_load) begin
            n_batch = i_batch;
        end else if (m_accept) begin
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                n_batch[k] = r_batch[k+1];
            end
            n_batch[MAX_RESULTS-1] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_batch <= n_batch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
        end else if (m_accept) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("result count exceeds batch size");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> ((r_cnt == '0) || (r_cnt == CNT_W'(1) && i_m_tready)))
        else $error("batch loaded over undelivered results");
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_cnt != '0) |=> (o_m_tvalid && r_cnt == $past(i_cnt)))
        else $error("loaded batch not presented");
`endif

endmodule
`default_nettype wire

@@ test/utf8_grapheme_segmenter_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 grapheme segmenter result checker
// Watches both stream channels of the segmenter, keeps its own model of the
// decoder and cluster state, and compares every result transaction field by
// field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module utf8_grapheme_segmenter_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_tvalid,
    input  wire        i_s_tready,
    input  wire [7:0]  i_s_tdata,   // text_byte
    input  wire        i_s_tlast,   // final_byte
    input  wire        i_m_tvalid,
    input  wire        i_m_tready,
    input  wire [55:0] i_m_tdata,   // char_code[20:0], byte_offset[52:21], unit_length[55:53]
    input  wire [2:0]  i_m_tuser,   // cluster_start[0], replaced[1], end_of_text[2]
    input  wire        i_m_tlast,   // run_last
    output int         o_errors,
    output int         o_outstanding,
    output int         o_checked
);
    import utfgs_pkg::*;

    typedef struct packed {
        logic [CP_W-1:0] char_code;
        logic [31:0]     byte_offset;
        logic [2:0]      unit_length;
        logic            cluster_start;
        logic            replaced;
        logic            end_of_text;
        logic            run_last;
    } t_seg_unit;

    t_seg_unit   unit_q[$];
    t_seg_unit   step_q[$];
    logic [7:0]  lead_buf[3];
    int          held;
    int          seq_len;
    logic [31:0] text_pos;
    t_mode       seg_mode;

    function automatic bit is_mark(logic [CP_W-1:0] cp);
        return (cp >= CP_CM_LO && cp <= CP_CM_HI) || (cp >= CP_CME_LO && cp <= CP_CME_HI) ||
               (cp >= CP_CMS_LO && cp <= CP_CMS_HI) || (cp >= CP_CMY_LO && cp <= CP_CMY_HI) ||
               (cp >= CP_HALF_LO && cp <= CP_HALF_HI) || (cp >= CP_VS_LO && cp <= CP_VS_HI) ||
               (cp >= CP_VSS_LO && cp <= CP_VSS_HI) ||
               (cp >= CP_SKIN_LO && cp <= CP_SKIN_HI);
    endfunction

    function automatic bit is_flag(logic [CP_W-1:0] cp);
        return cp >= CP_RI_LO && cp <= CP_RI_HI;
    endfunction

    task automatic clear_text();
        held     = 0;
        seq_len  = 0;
        text_pos = '0;
        seg_mode = MODE_START;
    endtask

    task automatic add_unit(input logic [CP_W-1:0] cp, input logic [31:0] off, input int len,
                            input logic repl);
        t_seg_unit u;
        bit        brk;
        brk = 1'b0;
        case (seg_mode)
            MODE_BASE: begin
                if (!is_mark(cp)) begin
                    if (cp == CP_ZWJ) begin
                        seg_mode = MODE_ZWJ;
                    end else begin
                        brk = 1'b1;
                    end
                end
            end
            MODE_ZWJ: begin
                seg_mode = MODE_BASE;
            end
            MODE_RI1: begin
                if (is_flag(cp)) begin
                    seg_mode = MODE_RI2;
                end else begin
                    brk = 1'b1;
                end
            end
            default: begin
                brk = 1'b1;
            end
        endcase
        if (brk) begin
            seg_mode = is_flag(cp) ? MODE_RI1 : MODE_BASE;
        end
        u               = '0;
        u.char_code     = cp;
        u.byte_offset   = off;
        u.unit_length   = len[2:0];
        u.cluster_start = brk;
        u.replaced      = repl;
        step_q          = {step_q, u};
    endtask

    task automatic flush_open();
        logic [31:0] base;
        base = text_pos - held;
        for (int i = 0; i < held; i++) begin
            add_unit(CP_REPL, base + i, 1, 1'b1);
        end
        held    = 0;
        seq_len = 0;
    endtask

    task automatic decode_fresh(input logic [7:0] b);
        int len;
        casez (b)
            8'b0???????: len = 1;
            8'b110?????: len = 2;
            8'b1110????: len = 3;
            8'b11110???: len = 4;
            default:     len = 0;
        endcase
        if (len == 1) begin
            add_unit({13'd0, b}, text_pos, 1, 1'b0);
        end else if (len == 0) begin
            add_unit(CP_REPL, text_pos, 1, 1'b1);
        end else begin
            lead_buf[0] = b;
            held        = 1;
            seq_len     = len;
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic fin);
        t_seg_unit       tail;
        logic [CP_W-1:0] cp;
        step_q.delete();
        if (held == 0) begin
            decode_fresh(b);
        end else if (b[7:6] != 2'b10) begin
            flush_open();
            decode_fresh(b);
        end else if (held + 1 == seq_len) begin
            case (seq_len)
                2:       cp = {16'd0, lead_buf[0][4:0]};
                3:       cp = {17'd0, lead_buf[0][3:0]};
                default: cp = {18'd0, lead_buf[0][2:0]};
            endcase
            for (int i = 1; i < held; i++) begin
                cp = {cp[14:0], lead_buf[i][5:0]};
            end
            cp = {cp[14:0], b[5:0]};
            add_unit(cp, text_pos - held, seq_len, 1'b0);
            held    = 0;
            seq_len = 0;
        end else begin
            lead_buf[held] = b;
            held++;
        end
        text_pos++;
        if (fin) begin
            flush_open();
            tail               = '0;
            tail.byte_offset   = text_pos;
            tail.cluster_start = 1'b1;
            tail.end_of_text   = 1'b1;
            step_q             = {step_q, tail};
            clear_text();
        end
        if (step_q.size() > 0) begin
            tail          = step_q.pop_back();
            tail.run_last = 1'b1;
            step_q        = {step_q, tail};
        end
        unit_q = {unit_q, step_q};
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: result %0d, %s: got 0x%0h, expected 0x%0h",
                 $realtime, o_checked, what, got, want);
        o_errors++;
    endtask

    task automatic check_result();
        t_seg_unit got;
        t_seg_unit want;
        got.char_code     = i_m_tdata[20:0];
        got.byte_offset   = i_m_tdata[52:21];
        got.unit_length   = i_m_tdata[55:53];
        got.cluster_start = i_m_tuser[0];
        got.replaced      = i_m_tuser[1];
        got.end_of_text   = i_m_tuser[2];
        got.run_last      = i_m_tlast;
        if (unit_q.size() == 0) begin
            report("unexpected transaction, char_code", 32'(got.char_code), '0);
        end else begin
            want = unit_q.pop_front();
            if (got.char_code != want.char_code) begin
                report("char_code", 32'(got.char_code), 32'(want.char_code));
            end
            if (got.byte_offset != want.byte_offset) begin
                report("byte_offset", got.byte_offset, want.byte_offset);
            end
            if (got.unit_length != want.unit_length) begin
                report("unit_length", 32'(got.unit_length), 32'(want.unit_length));
            end
            if (got.cluster_start != want.cluster_start) begin
                report("cluster_start", 32'(got.cluster_start), 32'(want.cluster_start));
            end
            if (got.replaced != want.replaced) begin
                report("replaced", 32'(got.replaced), 32'(want.replaced));
            end
            if (got.end_of_text != want.end_of_text) begin
                report("end_of_text", 32'(got.end_of_text), 32'(want.end_of_text));
            end
            if (got.run_last != want.run_last) begin
                report("run_last", 32'(got.run_last), 32'(want.run_last));
            end
        end
        o_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_text();
            unit_q.delete();
            o_outstanding <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                predict_byte(i_s_tdata, i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                check_result();
            end
            o_outstanding <= unit_q.size();
        end
    end

endmodule

@@ test/utf8_grapheme_segmenter_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 grapheme segmenter core testbench
// Feeds directed and random UTF-8 texts, well-formed and broken, through the
// segmenter under several idle and backpressure patterns, and lets the checker
// compare every result transaction against its own prediction.
// ----------------------------------------------------------------------------
module utf8_grapheme_segmenter_core_tb;
    import utfgs_pkg::*;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [55:0] m_tdata;
    wire  [2:0]  m_tuser;
    wire         m_tlast;

    int          errors;
    int          outstanding;
    int          checked;
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    bit          hold_req    = 1'b0;
    int          hold_left   = 0;
    int          bytes_sent  = 0;
    int          texts_sent  = 0;
    logic [7:0]  text_q[$];

    utf8_grapheme_segmenter_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    utf8_grapheme_segmenter_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tlast     (s_tlast),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tlast     (m_tlast),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    always #10 clk = ~clk;

    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_left = 300;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) begin
            send_byte(text_q[i], i == text_q.size() - 1);
        end
        text_q.delete();
        texts_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic put_byte(input logic [7:0] v);
        text_q = {text_q, v};
    endtask

    task automatic add_cp(input logic [20:0] cp);
        if (cp < 21'h80) begin
            put_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            put_byte({3'b110, cp[10:6]});
            put_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            put_byte({4'b1110, cp[15:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end else begin
            put_byte({5'b11110, cp[20:18]});
            put_byte({2'b10, cp[17:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end
    endtask

    task automatic add_random_unit();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            add_cp(21'($urandom_range(0, 8'h7F)));
        end else if (pick < 30) begin
            len = $urandom_range(2, 4);
            case (len)
                2:       put_byte({3'b110, 5'($urandom)});
                3:       put_byte({4'b1110, 4'($urandom)});
                default: put_byte({5'b11110, 3'($urandom)});
            endcase
            repeat (len - 1) put_byte({2'b10, 6'($urandom)});
        end else if (pick < 42) begin
            case ($urandom_range(0, 7))
                0:       add_cp(21'($urandom_range(CP_CM_LO, CP_CM_HI)));
                1:       add_cp(21'($urandom_range(CP_CME_LO, CP_CME_HI)));
                2:       add_cp(21'($urandom_range(CP_CMS_LO, CP_CMS_HI)));
                3:       add_cp(21'($urandom_range(CP_CMY_LO, CP_CMY_HI)));
                4:       add_cp(21'($urandom_range(CP_HALF_LO, CP_HALF_HI)));
                5:       add_cp(21'($urandom_range(CP_VS_LO, CP_VS_HI)));
                6:       add_cp(21'($urandom_range(CP_VSS_LO, CP_VSS_HI)));
                default: add_cp(21'($urandom_range(CP_SKIN_LO, CP_SKIN_HI)));
            endcase
        end else if (pick < 50) begin
            add_cp(CP_ZWJ);
        end else if (pick < 62) begin
            add_cp(21'($urandom_range(CP_RI_LO, CP_RI_HI)));
        end else if (pick < 80) begin
            add_cp(21'($urandom_range(0, 21'h1FFFFF)));
        end else begin
            case ($urandom_range(0, 2))
                0: begin
                    if ($urandom_range(0, 1)) begin
                        put_byte(8'($urandom_range(8'h80, 8'hBF)));
                    end else begin
                        put_byte(8'($urandom_range(8'hF8, 8'hFF)));
                    end
                end
                1: begin
                    len = $urandom_range(2, 4);
                    case (len)
                        2:       put_byte({3'b110, 5'($urandom)});
                        3:       put_byte({4'b1110, 4'($urandom)});
                        default: put_byte({5'b11110, 3'($urandom)});
                    endcase
                    repeat ($urandom_range(0, len - 2)) put_byte({2'b10, 6'($urandom)});
                end
                default: put_byte(8'($urandom));
            endcase
        end
    endtask

    task automatic send_random_text(input int units);
        repeat (units) add_random_unit();
        send_text();
    endtask

    initial begin
        int phase_start;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A mark and a ZWJ join the base letter, then a stray byte ends the text.
        text_q = '{8'h41, 8'hCC, 8'h81, 8'hE2, 8'h80, 8'h8D, 8'h41, 8'hFF};
        send_text();
        text_q = '{8'h00};
        send_text();
        // Flag pair followed by a skin modifier.
        text_q = '{8'hF0, 8'h9F, 8'h87, 8'hBA, 8'hF0, 8'h9F, 8'h87, 8'hB8,
                   8'hF0, 8'h9F, 8'h8F, 8'hBB};
        send_text();
        // Broken four-byte sequence on the final byte gives five results.
        text_q = '{8'hF0, 8'h90, 8'h80, 8'h7F};
        send_text();
        // Sequence still open at the final byte.
        text_q = '{8'hC3};
        send_text();
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 49; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 49; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 12) begin
                send_random_text($urandom_range(1, 6));
            end
            wait_drained();
            if (phase == 0) begin
                hold_req = 1'b1;
                send_random_text(8);
                wait_drained();
            end
        end

        repeat (16) @(posedge clk);
        $display("Sent %0d bytes in %0d texts under four idle patterns and one long stall;",
                 bytes_sent, texts_sent);
        $display("%0d result transactions compared, %0d mismatches.", checked, errors);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Timed out with %0d results outstanding.", outstanding);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
